/* src/pgr_pkg.sv */
package pgr_pkg;

	localparam int DEF_SCREEN_WIDTH  = 1920;
	localparam int DEF_SCREEN_HEIGHT = 1080;
	localparam int DEF_GLYPH_ROWS    = 21;
	localparam int DEF_SPACE_WIDTH   = 8;

	localparam int CODE_COUNT = 94;
	localparam int SLOT_W     = $clog2(CODE_COUNT);

	localparam logic [6:0] FIRST_CODE = 7'd32;
	localparam logic [6:0] LAST_CODE  = 7'd125;
	localparam logic [6:0] SPACE_CODE = 7'd32;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_SET  = 2'd1;
	localparam logic [1:0] ACT_DRAW = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [6:0]  char_code;
		logic [4:0]  row_index;
		logic [31:0] row_bits;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [23:0] color;
	} cmd_t;

	typedef struct packed {
		logic [16:0] line_y;
		logic [15:0] line_x;
		logic [31:0] pixel_mask;
		logic [23:0] paint_color;
		logic        last;
	} row_wr_t;

	// index of the highest set bit, zero for an empty row
	function automatic logic [4:0] top_bit(input logic [31:0] v);
		logic [4:0]  idx;
		logic [15:0] h;
		logic [7:0]  b;
		logic [3:0]  n;
		logic [1:0]  p;
		idx[4] = |v[31:16];
		h      = idx[4] ? v[31:16] : v[15:0];
		idx[3] = |h[15:8];
		b      = idx[3] ? h[15:8] : h[7:0];
		idx[2] = |b[7:4];
		n      = idx[2] ? b[7:4] : b[3:0];
		idx[1] = |n[3:2];
		p      = idx[1] ? n[3:2] : n[1:0];
		idx[0] = p[1];
		return idx;
	endfunction

endpackage

/* src/pgr_if.sv */
interface pgr_cmd_if;
	import pgr_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pgr_row_if;
	import pgr_pkg::*;

	logic    valid;
	logic    ready;
	row_wr_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* src/pgr_row_mask.sv */
module pgr_row_mask (
	input  logic [31:0] row_data,
	input  logic [4:0]  width,
	input  logic [31:0] col_mask,
	input  logic        row_on,
	output logic [31:0] mask
);
	logic [31:0] rev;
	logic [31:0] shifted;
	logic [31:0] width_mask;

	// mask bit k takes glyph bit (width - k): reverse, then align bit width to k = 0
	always_comb begin
		for (int i = 0; i < 32; i++) begin
			rev[i] = row_data[31 - i];
		end
		shifted    = rev >> (5'd31 - width);
		width_mask = ~(32'hFFFF_FFFF << width);
		mask       = row_on ? (shifted & width_mask & col_mask) : 32'h0;
	end
endmodule

/* src/proportional_glyph_renderer.sv */
// Proportional glyph renderer. Command beats load one glyph row (codes 32..125), set the
// cursor and ink, or draw a character. A set updates the cursor and ink at accept; a load writes the
// row at accept, then does a read-modify-write of the glyph width memory; a draw of a
// loaded glyph reads the glyph row memory one row per cycle, top row first, and stalls
// in any cycle in which the output register is held. One command is in flight at a
// time; the output register lets the last row write wait while the next command is
// taken. Draws of unloaded codes, codes outside the store and loads past the last row
// give no beats. Rows never loaded read as garbage.
module proportional_glyph_renderer #(
	parameter int SCREEN_WIDTH  = pgr_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = pgr_pkg::DEF_SCREEN_HEIGHT,
	parameter int GLYPH_ROWS    = pgr_pkg::DEF_GLYPH_ROWS,
	parameter int SPACE_WIDTH   = pgr_pkg::DEF_SPACE_WIDTH
) (
	input  logic     clk,
	input  logic     arst_n,
	pgr_cmd_if.sink  cmd,
	pgr_row_if.source paint
);
	import pgr_pkg::*;

	localparam int ROWS_DEPTH = CODE_COUNT * GLYPH_ROWS;
	localparam int ADDR_W     = $clog2(ROWS_DEPTH);
	localparam int ROW_W      = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

	localparam logic [ROW_W-1:0]  TOP_ROW  = ROW_W'(GLYPH_ROWS - 1);
	localparam logic [ADDR_W-1:0] ROWS_A   = ADDR_W'(GLYPH_ROWS);
	localparam logic [ADDR_W-1:0] TOP_A    = ADDR_W'(GLYPH_ROWS - 1);
	localparam logic [6:0]        ROWS_LIM = 7'(GLYPH_ROWS);
	localparam logic [16:0]       SW_L     = 17'(SCREEN_WIDTH);
	localparam logic [16:0]       SH_L     = 17'(SCREEN_HEIGHT);
	localparam logic [4:0]        SPACE_W  = 5'(SPACE_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_DRAW = 3'b100
	} state_t;

	state_t state_q;

	logic [31:0] rmem [ROWS_DEPTH];
	logic [31:0] rmem_rd_q;
	logic [4:0]  wmem [CODE_COUNT];
	logic [4:0]  wmem_rd_q;

	logic [CODE_COUNT-1:0] loaded_q;
	logic [15:0]           cursor_col_q;
	logic [15:0]           cursor_row_q;
	logic [23:0]           ink_q;

	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       bits_q;
	logic              row0_q;
	logic              space_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ROW_W-1:0]  row_q;
	logic [16:0]       line_y_q;
	logic [31:0]       col_mask_q;

	row_wr_t out_q;
	logic    out_valid_q;

	logic              cmd_acc;
	logic              code_ok;
	logic [SLOT_W-1:0] slot;
	logic [ADDR_W-1:0] base;
	logic              load_start;
	logic              draw_start;
	logic              set_cmd;
	logic              adv;
	logic              emit;
	logic              rmem_re;
	logic [ADDR_W-1:0] rmem_ra;
	logic [ADDR_W-1:0] rmem_wa;
	logic [4:0]        old_w;
	logic [4:0]        hb;
	logic [4:0]        new_w;
	logic [16:0]       col_room;
	logic [31:0]       col_mask;
	logic [31:0]       row_mask;

	assign cmd.ready   = (state_q == ST_IDLE);
	assign cmd_acc     = cmd.valid && cmd.ready;
	assign paint.valid = out_valid_q;
	assign paint.data  = out_q;

	always_comb begin
		code_ok    = (cmd.data.char_code >= FIRST_CODE) && (cmd.data.char_code <= LAST_CODE);
		slot       = SLOT_W'(cmd.data.char_code - FIRST_CODE);
		base       = ADDR_W'(ADDR_W'(slot) * ROWS_A);
		load_start = 1'b0;
		draw_start = 1'b0;
		set_cmd    = 1'b0;
		if (cmd_acc) begin
			unique case (cmd.data.action)
				ACT_LOAD: load_start = code_ok && ({2'b00, cmd.data.row_index} < ROWS_LIM);
				ACT_SET:  set_cmd = 1'b1;
				ACT_DRAW: draw_start = code_ok && loaded_q[slot];
				default:  ;
			endcase
		end
	end

	// the output register takes a new row when empty or when its beat leaves
	assign adv  = !out_valid_q || paint.ready;
	assign emit = (state_q == ST_DRAW) && adv;

	always_comb begin
		rmem_wa = ADDR_W'(base + ADDR_W'(cmd.data.row_index));
		rmem_re = draw_start || (emit && (row_q != '0));
		rmem_ra = draw_start ? ADDR_W'(base + TOP_A) : ADDR_W'(addr_q - ADDR_W'(1));
	end

	always_ff @(posedge clk) begin
		if (load_start) begin
			rmem[rmem_wa] <= cmd.data.row_bits;
		end
		if (rmem_re) begin
			rmem_rd_q <= rmem[rmem_ra];
		end
	end

	// width update on load; an entry never loaded counts as width zero
	always_comb begin
		old_w = loaded_q[slot_q] ? wmem_rd_q : 5'd0;
		hb    = top_bit(bits_q);
		priority if (space_q) begin
			new_w = SPACE_W;
		end else if (row0_q || (hb > old_w)) begin
			new_w = hb;
		end else begin
			new_w = old_w;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			wmem[slot_q] <= new_w;
		end
		if (load_start || draw_start) begin
			wmem_rd_q <= wmem[slot];
		end
	end

	// columns left on screen from the cursor, at most one full mask
	always_comb begin
		col_room = SW_L - {1'b0, cursor_col_q};
		priority if ({1'b0, cursor_col_q} >= SW_L) begin
			col_mask = 32'h0;
		end else if (col_room >= 17'd32) begin
			col_mask = 32'hFFFF_FFFF;
		end else begin
			col_mask = ~(32'hFFFF_FFFF << col_room[4:0]);
		end
	end

	pgr_row_mask u_row_mask (
		.row_data (rmem_rd_q),
		.width    (wmem_rd_q),
		.col_mask (col_mask_q),
		.row_on   (line_y_q < SH_L),
		.mask     (row_mask)
	);

	always_ff @(posedge clk) begin
		if (load_start) begin
			slot_q  <= slot;
			bits_q  <= cmd.data.row_bits;
			row0_q  <= (cmd.data.row_index == 5'd0);
			space_q <= (cmd.data.char_code == SPACE_CODE);
		end
		if (draw_start) begin
			addr_q     <= ADDR_W'(base + TOP_A);
			line_y_q   <= {1'b0, cursor_row_q};
			col_mask_q <= col_mask;
		end else if (emit) begin
			addr_q   <= ADDR_W'(addr_q - ADDR_W'(1));
			line_y_q <= 17'(line_y_q + 17'd1);
		end
		if (emit) begin
			out_q.line_y      <= line_y_q;
			out_q.line_x      <= cursor_col_q;
			out_q.pixel_mask  <= row_mask;
			out_q.paint_color <= ink_q;
			out_q.last        <= (row_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			loaded_q     <= '0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			ink_q        <= '0;
			row_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (paint.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (set_cmd) begin
						cursor_col_q <= cmd.data.pos_x;
						cursor_row_q <= cmd.data.pos_y;
						ink_q        <= cmd.data.color;
					end
					if (load_start) begin
						state_q <= ST_LOAD;
					end else if (draw_start) begin
						row_q   <= TOP_ROW;
						state_q <= ST_DRAW;
					end
				end
				ST_LOAD: begin
					loaded_q[slot_q] <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_DRAW: begin
					if (emit) begin
						if (row_q == '0) begin
							cursor_col_q <= 16'(cursor_col_q + 16'(wmem_rd_q));
							state_q      <= ST_IDLE;
						end else begin
							row_q <= ROW_W'(row_q - ROW_W'(1));
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_cmd_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !cmd.ready)
		else $error("command taken while an item is in flight");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAW |-> ({1'b0, row_q} < (ROW_W + 1)'(GLYPH_ROWS)))
		else $error("draw row counter out of range");

	a_cursor_move: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cursor_col_q) |-> ($past(set_cmd) || $past(emit && (row_q == '0))))
		else $error("cursor moved outside a set or the end of a draw");

	a_last_ends_draw: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (row_q == '0) |=> (state_q == ST_IDLE) && out_valid_q && out_q.last)
		else $error("final row write did not close the draw");

endmodule

/* tb/sv/tb.sv */
module tb;
	import pgr_pkg::*;

	localparam int SCREEN_WIDTH  = DEF_SCREEN_WIDTH;
	localparam int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT;
	localparam int GLYPH_ROWS    = DEF_GLYPH_ROWS;
	localparam int SPACE_WIDTH   = DEF_SPACE_WIDTH;

	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam int RANDOM_ITEMS = 180;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 400;
	localparam int WATCHDOG     = 2000;
	localparam int DRAIN_CYCLES = 2 * GLYPH_ROWS + 10;

	localparam int GLYPH_BLANK = 0;
	localparam int GLYPH_SOLID = 1;
	localparam int GLYPH_MIXED = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cmd_valid = 1'b0;
	cmd_t cmd_data = '0;
	logic paint_ready = 1'b0;

	pgr_cmd_if cmd_bus ();
	pgr_row_if paint_bus ();

	assign cmd_bus.valid = cmd_valid;
	assign cmd_bus.data = cmd_data;
	assign paint_bus.ready = paint_ready;

	proportional_glyph_renderer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.paint(paint_bus)
	);

	always #4 clk = ~clk;

	// font and cursor state as the block should hold it
	logic [31:0] font_rows [CODE_COUNT][GLYPH_ROWS];
	logic [4:0] font_width [CODE_COUNT] = '{default: '0};
	bit font_loaded [CODE_COUNT] = '{default: 1'b0};
	logic [15:0] pen_x = '0;
	logic [15:0] pen_y = '0;
	logic [23:0] ink = '0;

	row_wr_t pending_rows[$];
	cmd_t cmd_plan[$];
	logic [GLYPH_ROWS-1:0] rows_filled [CODE_COUNT] = '{default: '0};
	int active_items;

	int errors = 0;
	int cmd_beats = 0;
	int row_beats = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	bit tx_gappy = 1'b1;
	bit rx_gappy = 1'b1;
	int quiet = 0;

	function automatic logic [4:0] highest_one(input logic [31:0] v);
		logic [4:0] idx;
		idx = '0;
		for (int b = 0; b < 32; b++)
			if (v[b]) idx = 5'(b);
		return idx;
	endfunction

	function automatic bit in_store(input logic [6:0] code);
		return code >= FIRST_CODE && code <= LAST_CODE;
	endfunction

	task automatic predict_row_writes(input cmd_t c);
		int slot;
		int ly;
		int col;
		logic [4:0] w;
		logic [31:0] d;
		row_wr_t wr;
		if (c.action == ACT_SET) begin
			pen_x = c.pos_x;
			pen_y = c.pos_y;
			ink = c.color;
		end else if ((c.action == ACT_LOAD || c.action == ACT_DRAW) && in_store(c.char_code)) begin
			slot = c.char_code - FIRST_CODE;
			if (c.action == ACT_LOAD) begin
				if (c.row_index < GLYPH_ROWS) begin
					font_rows[slot][c.row_index] = c.row_bits;
					font_loaded[slot] = 1'b1;
					if (c.char_code == SPACE_CODE)
						font_width[slot] = 5'(SPACE_WIDTH);
					else if (c.row_index == 0 || highest_one(c.row_bits) > font_width[slot])
						font_width[slot] = highest_one(c.row_bits);
				end
			end else if (font_loaded[slot]) begin
				w = font_width[slot];
				col = pen_x;
				for (int r = GLYPH_ROWS - 1; r >= 0; r--) begin
					d = font_rows[slot][r];
					ly = pen_y + (GLYPH_ROWS - 1 - r);
					wr.line_y = ly[16:0];
					wr.line_x = pen_x;
					wr.pixel_mask = '0;
					if (ly < SCREEN_HEIGHT)
						for (int k = 0; k < w; k++)
							if (d[w - k] && col + k < SCREEN_WIDTH) wr.pixel_mask[k] = 1'b1;
					wr.paint_color = ink;
					wr.last = (r == 0);
					pending_rows.push_back(wr);
				end
				pen_x = pen_x + w;
			end
		end
	endtask

	task automatic check_row_write(input row_wr_t got);
		row_wr_t want;
		if (pending_rows.size() == 0) begin
			$display("%0t: unexpected row write, got %h", $time, got);
			errors++;
		end else begin
			want = pending_rows.pop_front();
			if (got.line_y !== want.line_y) begin
				$display("%0t: line_y expected %0d, got %0d", $time, want.line_y, got.line_y);
				errors++;
			end
			if (got.line_x !== want.line_x) begin
				$display("%0t: line_x expected %0d, got %0d", $time, want.line_x, got.line_x);
				errors++;
			end
			if (got.pixel_mask !== want.pixel_mask) begin
				$display("%0t: pixel_mask expected %h, got %h", $time, want.pixel_mask,
					got.pixel_mask);
				errors++;
			end
			if (got.paint_color !== want.paint_color) begin
				$display("%0t: paint_color expected %h, got %h", $time, want.paint_color,
					got.paint_color);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
				errors++;
			end
		end
	endtask

	// every field random, so the unused ones toggle too
	function automatic cmd_t noise_cmd(input logic [1:0] act);
		cmd_t c;
		c.action = act;
		c.char_code = 7'($urandom_range(0, 127));
		c.row_index = 5'($urandom_range(0, 31));
		c.row_bits = $urandom();
		c.pos_x = 16'($urandom_range(0, 65535));
		c.pos_y = 16'($urandom_range(0, 65535));
		c.color = 24'($urandom_range(0, 24'hFFFFFF));
		return c;
	endfunction

	task automatic plan(input cmd_t c);
		int slot;
		bit effective;
		slot = in_store(c.char_code) ? c.char_code - FIRST_CODE : 0;
		effective = 1'b0;
		case (c.action)
			ACT_SET: effective = 1'b1;
			ACT_LOAD: effective = in_store(c.char_code) && c.row_index < GLYPH_ROWS;
			ACT_DRAW: begin
				// drop draws of half-written glyphs: their empty rows are undefined
				if (in_store(c.char_code) && rows_filled[slot] != '0 && rows_filled[slot] != '1)
					return;
				effective = in_store(c.char_code) && rows_filled[slot] != '0;
			end
			default: effective = 1'b0;
		endcase
		if (c.action == ACT_LOAD && effective) rows_filled[slot][c.row_index] = 1'b1;
		if (effective) active_items++;
		cmd_plan.push_back(c);
	endtask

	task automatic plan_load(input int code, input int row, input logic [31:0] bits);
		cmd_t c;
		c = noise_cmd(ACT_LOAD);
		c.char_code = 7'(code);
		c.row_index = 5'(row);
		c.row_bits = bits;
		plan(c);
	endtask

	task automatic plan_draw(input int code);
		cmd_t c;
		c = noise_cmd(ACT_DRAW);
		c.char_code = 7'(code);
		plan(c);
	endtask

	task automatic plan_cursor(input logic [15:0] x, input logic [15:0] y,
		input logic [23:0] col);
		cmd_t c;
		c = noise_cmd(ACT_SET);
		c.pos_x = x;
		c.pos_y = y;
		c.color = col;
		plan(c);
	endtask

	function automatic logic [31:0] row_pattern(input int kind);
		case (kind)
			0: return '0;
			1: return '1;
			2: return 32'd1 << $urandom_range(0, 31);
			3: return $urandom() & ((32'd1 << $urandom_range(1, 31)) - 1);
			default: return $urandom();
		endcase
	endfunction

	// whole glyph in shuffled row order, sometimes with a second bottom row that resets width
	task automatic plan_glyph(input int code, input int style);
		int order [GLYPH_ROWS];
		int j;
		int t;
		for (int i = 0; i < GLYPH_ROWS; i++) order[i] = i;
		for (int i = GLYPH_ROWS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < GLYPH_ROWS; i++)
			case (style)
				GLYPH_BLANK: plan_load(code, order[i], '0);
				GLYPH_SOLID: plan_load(code, order[i], '1);
				default: plan_load(code, order[i], row_pattern($urandom_range(0, 4)));
			endcase
		if (style == GLYPH_MIXED && $urandom_range(0, 1))
			plan_load(code, 0, row_pattern($urandom_range(0, 4)));
	endtask

	function automatic int pick_full();
		int slots[$];
		for (int i = 0; i < CODE_COUNT; i++)
			if (rows_filled[i] == '1) slots.push_back(i);
		if (slots.size() == 0) return -1;
		return slots[$urandom_range(0, slots.size() - 1)];
	endfunction

	function automatic logic [15:0] pick_col();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 16'($urandom_range(1890, 1930));
			2: return 16'($urandom_range(65500, 65535));
			3: return 16'($urandom_range(0, 1900));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_row();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 16'($urandom_range(1055, 1085));
			2: return 16'($urandom_range(65520, 65535));
			3: return 16'($urandom_range(0, 1050));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic build_stimulus();
		int pick;
		int slot;
		cmd_t c;
		// ignored and empty cases first
		plan(noise_cmd(ACT_NONE));
		plan_draw(65);
		plan_load(0, 0, '1);
		plan_load(31, 3, $urandom());
		plan_load(126, 5, $urandom());
		plan_load(127, 20, '1);
		plan_draw(0);
		plan_draw(31);
		plan_draw(126);
		plan_draw(127);
		plan_load(40, GLYPH_ROWS, '1);
		plan_load(40, 31, '1);
		plan_draw(40);
		plan_cursor('1, '1, '1);
		plan_draw(66);
		plan_cursor('0, '0, '0);

		active_items = 0;
		plan_glyph(SPACE_CODE, GLYPH_MIXED);
		plan_glyph(LAST_CODE, GLYPH_SOLID);
		plan_glyph(33, GLYPH_BLANK);
		plan_cursor('0, '0, 24'($urandom_range(0, 24'hFFFFFF)));
		plan_draw(SPACE_CODE);
		plan_draw(LAST_CODE);
		plan_draw(33);
		plan_cursor(16'd1900, 16'd1070, '1);
		plan_draw(LAST_CODE);
		plan_draw(LAST_CODE);
		// advance past 65535 and land on a visible column
		plan_cursor(16'd65520, 16'd65530, 24'h00FF00);
		plan_draw(LAST_CODE);
		plan_draw(SPACE_CODE);

		while (active_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				plan_glyph($urandom_range(FIRST_CODE, LAST_CODE), $urandom_range(0, 2));
			end else if (pick < 20) begin
				plan_cursor(pick_col(), pick_row(), 24'($urandom_range(0, 24'hFFFFFF)));
			end else if (pick < 70) begin
				slot = pick_full();
				if (slot >= 0) plan_draw(slot + FIRST_CODE);
			end else if (pick < 76) begin
				plan_draw($urandom_range(0, 127));
			end else if (pick < 86) begin
				slot = pick_full();
				if (slot >= 0)
					plan_load(slot + FIRST_CODE, $urandom_range(0, GLYPH_ROWS - 1),
						row_pattern($urandom_range(0, 4)));
			end else begin
				c = noise_cmd(2'($urandom_range(0, 3)));
				plan(c);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd_data <= '0;
			tx_wait = 0;
		end else if (!cmd_valid || cmd_bus.ready) begin
			if (cmd_valid) begin
				predict_row_writes(cmd_data);
				cmd_beats++;
				if (cmd_beats % 48 == 0) tx_gappy = $urandom_range(0, 2) != 0;
			end
			if (tx_wait > 0) begin
				tx_wait--;
				cmd_valid <= 1'b0;
			end else if (cmd_plan.size() > 0) begin
				cmd_data <= cmd_plan.pop_front();
				cmd_valid <= 1'b1;
				tx_wait = tx_gappy ? $urandom_range(0, 11) : 0;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paint_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (paint_bus.valid && paint_ready) begin
				check_row_write(paint_bus.data);
				row_beats++;
				if (row_beats % 48 == 0) rx_gappy = $urandom_range(0, 2) != 0;
				rx_wait = rx_gappy ? $urandom_range(0, 11) : 0;
				// hold off long enough for the block to back up into the command side
				if (row_beats == HOLD_AT) rx_wait = HOLD_CYCLES;
			end
			if (rx_wait > 0) begin
				rx_wait--;
				paint_ready <= 1'b0;
			end else begin
				paint_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_bus.ready) || (paint_bus.valid && paint_ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		build_stimulus();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (cmd_plan.size() != 0 || cmd_valid) @(posedge clk);
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rows.size() != 0) begin
			$display("%0t: %0d row writes never arrived", $time, pending_rows.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
